>>> rtl/core/ngagc_pkg.sv
// Shared types, constants and the tanh table for the mic noise gate / AGC block.
// No dependencies.
`default_nettype none
package ngagc_pkg;

  localparam int FRAME_DEPTH = 256;
  localparam int POS_W  = $clog2(FRAME_DEPTH);
  localparam int LEN_W  = POS_W + 1;
  localparam int ADDR_W = POS_W + 1;
  localparam int SUM_W  = 48;
  localparam int DEN_W  = 16;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_DEPTH - 1);

  localparam logic [14:0] GATE_OPEN_THR   = 15'd721;
  localparam logic [14:0] GATE_CLOSE_THR  = 15'd459;
  localparam logic [15:0] GATE_HALF       = 16'd32768;
  localparam logic [15:0] GATE_ALPHA_UP   = 16'd36045;
  localparam logic [15:0] GATE_ALPHA_DOWN = 16'd7864;
  localparam logic [15:0] GATE_MUTE       = 16'd3277;
  localparam logic [15:0] GATE_AGC_MIN    = 16'd16384;
  localparam logic [14:0] AGC_ONE         = 15'd16384;
  localparam logic [14:0] AGC_MIN         = 15'd9830;
  localparam logic [14:0] AGC_MAX         = 15'd26214;
  localparam logic [15:0] AGC_RATE_MUTE   = 16'd5243;
  localparam logic [15:0] AGC_RATE_TRACK  = 16'd3277;
  localparam logic [15:0] AGC_RATE_IDLE   = 16'd3932;
  localparam logic [14:0] FB_MAX          = 15'd24576;
  localparam logic [14:0] CLIP_KNEE       = 15'd24576;
  localparam logic [14:0] AGC_TARGET_RST  = 15'd3277;
  localparam logic [14:0] FB_RST          = 15'd16384;

  typedef enum logic {
    CFG_AGC_TARGET    = 1'b0,
    CFG_FEEDBACK_GAIN = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] sample_in;
    logic               frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [14:0]        frame_rms;
    logic [15:0]        gate_level;
    logic [14:0]        agc_gain_out;
    logic               out_last;
  } out_item_t;

  // state held by the frame-end unit
  typedef struct packed {
    logic [14:0] rms;
    logic [15:0] gate;
    logic [14:0] gain;
    logic [17:0] applied;
  } calc_stat_t;

  function automatic logic [14:0] tanh_tab(input logic [5:0] idx);
    logic [14:0] v;
    case (idx)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd4075;  6'd2:  v = 15'd8025;
      6'd3:  v = 15'd11743; 6'd4:  v = 15'd15143; 6'd5:  v = 15'd18173;
      6'd6:  v = 15'd20813; 6'd7:  v = 15'd23066; 6'd8:  v = 15'd24956;
      6'd9:  v = 15'd26519; 6'd10: v = 15'd27797; 6'd11: v = 15'd28830;
      6'd12: v = 15'd29660; 6'd13: v = 15'd30322; 6'd14: v = 15'd30847;
      6'd15: v = 15'd31262; 6'd16: v = 15'd31589; 6'd17: v = 15'd31846;
      6'd18: v = 15'd32048; 6'd19: v = 15'd32206; 6'd20: v = 15'd32329;
      6'd21: v = 15'd32426; 6'd22: v = 15'd32501; 6'd23: v = 15'd32560;
      6'd24: v = 15'd32606; 6'd25: v = 15'd32642; 6'd26: v = 15'd32670;
      6'd27: v = 15'd32691; 6'd28: v = 15'd32708; 6'd29: v = 15'd32722;
      6'd30: v = 15'd32732; 6'd31: v = 15'd32740;
      default: v = 15'd32746;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/noise_gate_agc_frame.sv
// Top level of the mic noise gate / AGC block: sample path, fill control, config.
// Depends on ngagc_pkg, ngagc_ram, ngagc_calc.
//
// Usage
//  in_*  : valid/ready channel of mic samples (Q1.15) with a frame_end flag.
//  out_* : valid/ready channel, one result per input transfer, carrying the
//          previous frame's sample at the same position (gated, gain-scaled,
//          soft-clipped) plus the current RMS, gate level and AGC gain.
//  cfg_* : write-only registers, index 0 agc_target, 1 feedback_gain (capped
//          at 1.5); write only while the block is idle.
// Timing
//  A sample passes the six steps of the sample path in order: store read, gain
//  multiply, clip, interpolation, sign, output load. The next input transfer is
//  taken only once the result is in the output register, so a new sample is not
//  taken before the last one is through. A frame end also waits for a 48-step
//  serial divide, a 24-step square root, a second 48-step divide for the AGC
//  target when gate and RMS pass their limits, and the gain products unless muted.
// Reset: store contents are not cleared (only written positions are ever
//  played back); gate 0, AGC gain 1.0, first frame plays silence.
// Stall: a held output keeps its result; at most one further sample is
//  processed and then waits for the output register to free.
`default_nettype none
module noise_gate_agc_frame
  import ngagc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire cfg_idx_t  cfg_addr,
  input  wire logic [14:0] cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE, T_MUL, T_CLIP, T_INTERP, T_FIN, T_WAIT, T_OUT
  } tstate_t;

  tstate_t          st_r;
  logic             bank_r;
  logic [POS_W-1:0] pos_r;
  logic [LEN_W-1:0] prev_len_r;
  logic [SUM_W-1:0] sum_r;
  logic [14:0]      agc_target_r, fb_r;

  logic signed [15:0] smp_r;
  logic             last_r, play_r, neg_r;
  logic [33:0]      mprod_r;
  logic [17:0]      mag_r;
  logic             knee_r, sat_r;
  logic [5:0]       idx_r;
  logic [11:0]      frac_r;
  logic [15:0]      res_r;
  logic [14:0]      tlo_r, tdiff_r;

  logic             out_valid_r;
  out_item_t        out_r;

  logic             in_xfer, out_free;
  logic [15:0]      rdata;
  logic [15:0]      prev_abs;
  logic [17:0]      mag_c;
  logic [19:0]      x_c;
  logic [14:0]      t_c, c_c;
  logic             calc_start, calc_busy, calc_done;
  calc_stat_t       stat;

  assign in_ready = (st_r == T_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  ngagc_ram u_ram (
    .clk   (clk),
    .we    (in_xfer),
    .waddr ({bank_r, pos_r}),
    .wdata (in_data.sample_in),
    .raddr ({~bank_r, pos_r}),
    .rdata (rdata)
  );

  assign calc_start = (st_r == T_FIN) && last_r;

  ngagc_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (calc_start),
    .sum        (sum_r),
    .len        (LEN_W'(pos_r) + LEN_W'(1)),
    .agc_target (agc_target_r),
    .fb_gain    (fb_r),
    .busy       (calc_busy),
    .done       (calc_done),
    .stat       (stat)
  );

  always_comb begin
    prev_abs = rdata[15] ? 16'(-rdata) : rdata;
    mag_c    = 18'((mprod_r + 34'd32768) >> 16);
    x_c      = 20'(({2'b0, mag_c} - 20'(CLIP_KNEE)) * 20'd5 >> 1);
    t_c      = 15'(tlo_r + 15'(({12'b0, tdiff_r} * {15'b0, frac_r} + 27'd2048) >> 12));
    c_c      = knee_r ? mag_r[14:0]
             : CLIP_KNEE + 15'(((sat_r ? tanh_tab(6'd32) : t_c) + 15'd2) >> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= T_IDLE;
      bank_r       <= 1'b0;
      pos_r        <= '0;
      prev_len_r   <= '0;
      sum_r        <= '0;
      agc_target_r <= AGC_TARGET_RST;
      fb_r         <= FB_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_AGC_TARGET:    agc_target_r <= cfg_wdata;
          CFG_FEEDBACK_GAIN: fb_r <= (cfg_wdata > FB_MAX) ? FB_MAX : cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        T_IDLE: begin
          if (in_xfer) begin
            smp_r  <= in_data.sample_in;
            last_r <= in_data.frame_end || (pos_r == POS_LAST);
            play_r <= LEN_W'(pos_r) < prev_len_r;
            st_r   <= T_MUL;
          end
        end
        T_MUL: begin
          neg_r   <= rdata[15];
          mprod_r <= prev_abs * stat.applied;
          sum_r   <= sum_r + SUM_W'(unsigned'(32'(smp_r * smp_r)));
          st_r    <= T_CLIP;
        end
        T_CLIP: begin
          mag_r  <= mag_c;
          knee_r <= mag_c <= 18'(CLIP_KNEE);
          sat_r  <= x_c[19:12] >= 8'd32;
          idx_r  <= x_c[17:12];
          frac_r <= x_c[11:0];
          st_r   <= T_INTERP;
        end
        T_INTERP: begin
          tlo_r   <= tanh_tab(idx_r);
          tdiff_r <= tanh_tab(idx_r + 6'd1) - tanh_tab(idx_r);
          st_r    <= T_FIN;
          // resolve the clip path into the signed result next
          res_r   <= '0;
        end
        T_FIN: begin
          res_r <= !play_r ? 16'd0 : (neg_r ? 16'(-{1'b0, c_c}) : {1'b0, c_c});
          if (last_r) begin
            prev_len_r <= LEN_W'(pos_r) + LEN_W'(1);
            bank_r     <= ~bank_r;
            pos_r      <= '0;
            sum_r      <= '0;
            st_r       <= T_WAIT;
          end else begin
            pos_r <= pos_r + POS_W'(1);
            st_r  <= T_OUT;
          end
        end
        T_WAIT: begin
          if (calc_done) begin
            st_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_r       <= '{sample_out: res_r, frame_rms: stat.rms,
                             gate_level: stat.gate, agc_gain_out: stat.gain,
                             out_last: last_r};
            st_r        <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    calc_busy |-> !in_ready) else $error("input taken during frame-end work");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    prev_len_r <= LEN_W'(FRAME_DEPTH)) else $error("previous length too large");
`endif

endmodule
`default_nettype wire

>>> rtl/core/ngagc_ram.sv
// Ping-pong frame store: one write port, one registered read port.
// Depends on ngagc_pkg.
`default_nettype none
module ngagc_ram
  import ngagc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [15:0]       wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [15:0]       rdata
);

  logic [15:0] mem [0:2*FRAME_DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ngagc_calc.sv
// Frame-end unit: RMS (serial divide + square root), hysteresis gate, AGC update
// and applied-gain product. Depends on ngagc_pkg.
`default_nettype none
module ngagc_calc
  import ngagc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] sum,
  input  wire logic [LEN_W-1:0] len,
  input  wire logic [14:0]      agc_target,
  input  wire logic [14:0]      fb_gain,
  output logic                  busy,
  output logic                  done,
  output calc_stat_t            stat
);

  typedef enum logic [3:0] {
    F_IDLE, F_DIV, F_SQRT, F_GATE1, F_GATE2, F_AGC1, F_AGC2,
    F_APP1, F_APP2, F_APP3
  } fstate_t;

  fstate_t            st_r;
  logic [SUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r, rem_r;
  logic [5:0]         cnt_r;
  logic               div_sqrt_r;   // 1: quotient feeds the square root
  logic [SUM_W-1:0]   sq_v_r, sq_res_r, sq_bit_r;
  logic [14:0]        rms_r, gain_r, agc_tgt_r;
  logic [15:0]        gate_r, rate_r;
  logic [17:0]        app_r;
  logic               up_r, mute_r, done_r;
  logic [32:0]        prod_r;
  logic [29:0]        p1_r;
  logic [45:0]        p2_r;

  logic [DEN_W:0]     rem_sh;
  logic               q_bit;
  logic [SUM_W-1:0]   sq_try;
  logic [16:0]        step;
  logic [17:0]        gate_nx;
  logic [14:0]        thr;
  logic [15:0]        gain_nx;

  always_comb begin
    rem_sh  = {rem_r, num_r[SUM_W-1]};
    q_bit   = rem_sh >= {1'b0, den_r};
    sq_try  = sq_res_r + sq_bit_r;
    step    = 17'((prod_r + 33'd32768) >> 16);
    gate_nx = up_r ? ({2'b0, gate_r} + {1'b0, step}) : ({2'b0, gate_r} - {1'b0, step});
    thr     = (gate_r > GATE_HALF) ? GATE_CLOSE_THR : GATE_OPEN_THR;
    gain_nx = up_r ? ({1'b0, gain_r} + step[15:0]) : ({1'b0, gain_r} - step[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      rms_r  <= '0;
      gate_r <= '0;
      gain_r <= AGC_ONE;
      app_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        F_IDLE: begin
          if (start) begin
            num_r      <= sum;
            den_r      <= DEN_W'(len);
            rem_r      <= '0;
            cnt_r      <= 6'(SUM_W);
            div_sqrt_r <= 1'b1;
            st_r       <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
          num_r <= {num_r[SUM_W-2:0], q_bit};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            if (div_sqrt_r) begin
              sq_v_r   <= {num_r[SUM_W-2:0], q_bit};
              sq_res_r <= '0;
              sq_bit_r <= SUM_W'(1) << (SUM_W - 2);
              st_r     <= F_SQRT;
            end else begin
              // desired gain, clamped
              if ({num_r[SUM_W-2:0], q_bit} < SUM_W'(AGC_MIN)) begin
                agc_tgt_r <= AGC_MIN;
              end else if ({num_r[SUM_W-2:0], q_bit} > SUM_W'(AGC_MAX)) begin
                agc_tgt_r <= AGC_MAX;
              end else begin
                agc_tgt_r <= num_r[13:0] == 14'd0 && 1'b0 ? AGC_MIN
                           : {num_r[13:0], q_bit};
              end
              rate_r <= AGC_RATE_TRACK;
              st_r   <= F_AGC1;
            end
          end
        end
        F_SQRT: begin
          if (sq_v_r >= sq_try) begin
            sq_v_r   <= sq_v_r - sq_try;
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (sq_bit_r == SUM_W'(1)) begin
            st_r <= F_GATE1;
          end
        end
        F_GATE1: begin
          rms_r <= (sq_res_r > SUM_W'(32767)) ? 15'd32767 : sq_res_r[14:0];
          st_r  <= F_GATE2;
          if (((sq_res_r > SUM_W'(32767)) ? 15'd32767 : sq_res_r[14:0]) > thr) begin
            up_r   <= 1'b1;
            prod_r <= 33'(GATE_ALPHA_UP * (17'h10000 - {1'b0, gate_r}));
          end else begin
            up_r   <= 1'b0;
            prod_r <= 33'(GATE_ALPHA_DOWN * {1'b0, gate_r});
          end
        end
        F_GATE2: begin
          mute_r    <= 1'b0;
          agc_tgt_r <= AGC_ONE;
          rate_r    <= AGC_RATE_IDLE;
          st_r      <= F_AGC1;
          if (gate_nx < {2'b0, GATE_MUTE}) begin
            gate_r <= '0;
            app_r  <= '0;
            mute_r <= 1'b1;
            rate_r <= AGC_RATE_MUTE;
          end else begin
            gate_r <= (gate_nx > 18'd65535) ? 16'hFFFF : gate_nx[15:0];
            if (gate_nx > {2'b0, GATE_AGC_MIN} && rms_r > GATE_CLOSE_THR) begin
              num_r      <= SUM_W'({agc_target, 14'd0});
              den_r      <= DEN_W'(rms_r);
              rem_r      <= '0;
              cnt_r      <= 6'(SUM_W);
              div_sqrt_r <= 1'b0;
              st_r       <= F_DIV;
            end
          end
        end
        F_AGC1: begin
          up_r <= agc_tgt_r >= gain_r;
          if (agc_tgt_r >= gain_r) begin
            prod_r <= 33'(rate_r * (agc_tgt_r - gain_r));
          end else begin
            prod_r <= 33'(rate_r * (gain_r - agc_tgt_r));
          end
          st_r <= F_AGC2;
        end
        F_AGC2: begin
          if (gain_nx < {1'b0, AGC_MIN}) begin
            gain_r <= AGC_MIN;
          end else if (gain_nx > {1'b0, AGC_MAX}) begin
            gain_r <= AGC_MAX;
          end else begin
            gain_r <= gain_nx[14:0];
          end
          if (mute_r) begin
            done_r <= 1'b1;
            st_r   <= F_IDLE;
          end else begin
            st_r <= F_APP1;
          end
        end
        F_APP1: begin
          p1_r <= gain_r * fb_gain;
          st_r <= F_APP2;
        end
        F_APP2: begin
          p2_r <= p1_r * gate_r;
          st_r <= F_APP3;
        end
        F_APP3: begin
          app_r  <= 18'((p2_r + 46'(1 << 27)) >> 28);
          done_r <= 1'b1;
          st_r   <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign busy = (st_r != F_IDLE) || start;
  assign done = done_r;
  assign stat = '{rms: rms_r, gate: gate_r, gain: gain_r, applied: app_r};

`ifndef SYNTHESIS
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r >= AGC_MIN && gain_r <= AGC_MAX) else $error("agc gain out of range");
  a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (gate_r == 16'd0) |-> (app_r == 18'd0 || st_r != F_IDLE))
    else $error("closed gate with non-zero applied gain");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> st_r == F_IDLE) else $error("done while busy");
`endif

endmodule
`default_nettype wire
